// ===== rtl/pest_pkg.sv =====
// Shared types and codes for the priority event subscriber table.
package pest_pkg;

  typedef enum logic [1:0] {
    OP_SUBSCRIBE = 2'd0,
    OP_CANCEL    = 2'd1,
    OP_DISPATCH  = 2'd2,
    OP_NOP       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_SUB,
    S_CAN,
    S_DSP,
    S_DFIN
  } state_e;

  typedef struct packed {
    logic [7:0] handler;
    logic [7:0] prio;
  } entry_t;

endpackage

// ===== rtl/pest_entry_ram.sv =====
// List entry memory: one write port, one registered read port.
module pest_entry_ram import pest_pkg::*; #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pest_count_ram.sv =====
// List length memory with per-row valid bits; an unwritten row reads as zero.
module pest_count_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [DW-1:0] rdata_q;
  logic rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ===== rtl/priority_event_subscriber_table.sv =====
// Priority event subscriber table: sequencer around the list length and entry memories.
//
// Each event type owns a list of up to MAX_SUBS (handler, priority) entries kept in
// ascending priority order in a single-port-read entry memory; list lengths sit in a
// separate small memory. Fault, no-operation and invalid-event requests keep busy low
// and strobe their result in the next cycle. Subscribe moves each larger entry up one
// slot to make room; a subscribe to a full list and a dispatch or cancel on an empty
// list end once the list length is read, with a single result word. The sequencer
// walks the row one entry per cycle through the entry memory's single read port.
// Dispatch results cannot be held off, and entries with handler zero give no word;
// every item ends with exactly one word marked last. After reset no clearing pass is
// needed.
module priority_event_subscriber_table import pest_pkg::*; #(
  parameter int NUM_EVENTS = 16,
  parameter int MAX_SUBS   = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [7:0]  event_id_i,
  input  logic [7:0]  priority_req_i,
  input  logic [7:0]  handler_id_i,
  input  logic [31:0] aux_data_i,
  output logic        strobe_o,
  output logic [1:0]  status_o,
  output logic        handler_valid_o,
  output logic [7:0]  handler_out_o,
  output logic [7:0]  event_out_o,
  output logic [31:0] data_out_o,
  output logic        fault_o,
  output logic        last_o
);

  localparam int EW    = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
  localparam int IW    = (MAX_SUBS > 1) ? $clog2(MAX_SUBS) : 1;
  localparam int CW    = $clog2(MAX_SUBS + 1);
  localparam int DEPTH = NUM_EVENTS * MAX_SUBS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [8:0]    NumEv  = 9'(NUM_EVENTS);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_SUBS);
  localparam logic [CW-1:0] One    = CW'(1);

  state_e state_q, state_d;
  op_e op_q, op_d;
  logic [7:0]  ev_q, ev_d;
  logic [7:0]  prio_q, prio_d;
  logic [7:0]  hid_q, hid_d;
  logic [31:0] data_q, data_d;
  logic fault_q, fault_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] pos_q, pos_d;
  logic found_q, found_d;
  logic pend_vld_q, pend_vld_d;
  logic [7:0] pend_h_q, pend_h_d;

  logic res_vld_q, res_vld_d;
  status_e res_status_q, res_status_d;
  logic res_hvld_q, res_hvld_d;
  logic [7:0] res_handler_q, res_handler_d;
  logic [7:0] res_event_q, res_event_d;
  logic [31:0] res_data_q, res_data_d;
  logic res_fault_q, res_fault_d;
  logic res_last_q, res_last_d;

  logic accept;
  logic ev_invalid;
  logic [CW-1:0] cnt_rdata;
  logic cnt_we;
  logic [CW-1:0] cnt_wdata;
  logic ent_we, ent_re;
  logic [IW-1:0] ent_widx, ent_ridx;
  entry_t ent_wdata, ent_rdata;
  logic [AW-1:0] ent_base, ent_waddr, ent_raddr;
  logic sub_shift, can_match, scan_end;

  assign accept     = start && !busy;
  assign busy       = (state_q != S_IDLE);
  assign ev_invalid = ({1'b0, event_id_i} >= NumEv);
  assign ent_base   = AW'(ev_q[EW-1:0]) * AW'(MAX_SUBS);
  assign ent_waddr  = ent_base + AW'(ent_widx);
  assign ent_raddr  = ent_base + AW'(ent_ridx);
  assign sub_shift  = (pos_q != '0) && (prio_q < ent_rdata.prio);
  assign can_match  = (ent_rdata.handler == hid_q);
  assign scan_end   = (pos_q == n_q - One);

  pest_count_ram #(
    .DEPTH (NUM_EVENTS),
    .AW    (EW),
    .DW    (CW)
  ) u_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cnt_we),
    .waddr_i (ev_q[EW-1:0]),
    .wdata_i (cnt_wdata),
    .raddr_i (event_id_i[EW-1:0]),
    .rdata_o (cnt_rdata)
  );

  pest_entry_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_entry (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && !fault_q && (op_e'(op_i) != OP_NOP) && !ev_invalid) begin
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        unique case (op_q)
          OP_SUBSCRIBE: state_d = (cnt_rdata >= MaxCnt) ? S_IDLE : S_SUB;
          OP_CANCEL:    state_d = (cnt_rdata == '0) ? S_IDLE : S_CAN;
          OP_DISPATCH:  state_d = (cnt_rdata == '0) ? S_IDLE : S_DSP;
          OP_NOP:       state_d = S_IDLE;
        endcase
      end
      S_SUB:   state_d = sub_shift ? S_SUB : S_IDLE;
      S_CAN:   state_d = scan_end ? S_IDLE : S_CAN;
      S_DSP:   state_d = scan_end ? S_DFIN : S_DSP;
      S_DFIN:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, memory accesses and result words.
  always_comb begin
    op_d          = op_q;
    ev_d          = ev_q;
    prio_d        = prio_q;
    hid_d         = hid_q;
    data_d        = data_q;
    fault_d       = fault_q;
    n_d           = n_q;
    pos_d         = pos_q;
    found_d       = found_q;
    pend_vld_d    = pend_vld_q;
    pend_h_d      = pend_h_q;
    res_vld_d     = 1'b0;
    res_status_d  = res_status_q;
    res_hvld_d    = res_hvld_q;
    res_handler_d = res_handler_q;
    res_event_d   = res_event_q;
    res_data_d    = res_data_q;
    res_fault_d   = res_fault_q;
    res_last_d    = res_last_q;
    cnt_we        = 1'b0;
    cnt_wdata     = '0;
    ent_we        = 1'b0;
    ent_widx      = '0;
    ent_wdata     = '0;
    ent_re        = 1'b0;
    ent_ridx      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d   = op_e'(op_i);
          ev_d   = event_id_i;
          prio_d = priority_req_i;
          hid_d  = handler_id_i;
          data_d = aux_data_i;
          if (fault_q || (op_e'(op_i) == OP_NOP) || ev_invalid) begin
            res_vld_d     = 1'b1;
            res_hvld_d    = 1'b0;
            res_handler_d = '0;
            res_event_d   = event_id_i;
            res_data_d    = '0;
            res_fault_d   = fault_q;
            res_last_d    = 1'b1;
            if (fault_q) begin
              res_status_d = ST_FULL;
            end else if (op_e'(op_i) == OP_NOP) begin
              res_status_d = ST_OK;
            end else begin
              res_status_d = ST_INVALID;
            end
          end
        end
      end
      S_HEAD: begin
        n_d           = cnt_rdata;
        found_d       = 1'b0;
        pend_vld_d    = 1'b0;
        res_status_d  = ST_OK;
        res_hvld_d    = 1'b0;
        res_handler_d = '0;
        res_event_d   = ev_q;
        res_data_d    = '0;
        res_fault_d   = fault_q;
        res_last_d    = 1'b1;
        unique case (op_q)
          OP_SUBSCRIBE: begin
            if (cnt_rdata >= MaxCnt) begin
              fault_d      = 1'b1;
              res_vld_d    = 1'b1;
              res_status_d = ST_FULL;
              res_fault_d  = 1'b1;
            end else begin
              // Start the walk from the tail: pos is the free slot.
              pos_d = cnt_rdata;
              if (cnt_rdata != '0) begin
                ent_re   = 1'b1;
                ent_ridx = IW'(cnt_rdata - One);
              end
            end
          end
          OP_CANCEL, OP_DISPATCH: begin
            pos_d = '0;
            if (cnt_rdata == '0) begin
              res_vld_d = 1'b1;
            end else begin
              ent_re   = 1'b1;
              ent_ridx = '0;
            end
          end
          OP_NOP: begin
            res_vld_d = 1'b1;
          end
        endcase
      end
      S_SUB: begin
        ent_we   = 1'b1;
        ent_widx = IW'(pos_q);
        if (sub_shift) begin
          // Move the larger entry up one slot and fetch the next one down.
          ent_wdata = ent_rdata;
          pos_d     = pos_q - One;
          if (pos_q > One) begin
            ent_re   = 1'b1;
            ent_ridx = IW'(pos_q - CW'(2));
          end
        end else begin
          ent_wdata.handler = hid_q;
          ent_wdata.prio    = prio_q;
          cnt_we            = 1'b1;
          cnt_wdata         = n_q + One;
          res_vld_d         = 1'b1;
        end
      end
      S_CAN: begin
        if (found_q) begin
          // Close the gap left by the removed entry.
          ent_we    = 1'b1;
          ent_widx  = IW'(pos_q - One);
          ent_wdata = ent_rdata;
        end else if (can_match) begin
          found_d = 1'b1;
        end
        if (scan_end) begin
          if (found_q || can_match) begin
            cnt_we    = 1'b1;
            cnt_wdata = n_q - One;
          end
          res_vld_d = 1'b1;
        end else begin
          pos_d    = pos_q + One;
          ent_re   = 1'b1;
          ent_ridx = IW'(pos_q + One);
        end
      end
      S_DSP: begin
        // Hold one handler back so the final one can carry last.
        if (ent_rdata.handler != '0) begin
          if (pend_vld_q) begin
            res_vld_d     = 1'b1;
            res_hvld_d    = 1'b1;
            res_handler_d = pend_h_q;
            res_data_d    = data_q;
            res_last_d    = 1'b0;
          end
          pend_vld_d = 1'b1;
          pend_h_d   = ent_rdata.handler;
        end
        if (!scan_end) begin
          pos_d    = pos_q + One;
          ent_re   = 1'b1;
          ent_ridx = IW'(pos_q + One);
        end
      end
      S_DFIN: begin
        res_vld_d  = 1'b1;
        res_last_d = 1'b1;
        if (pend_vld_q) begin
          res_hvld_d    = 1'b1;
          res_handler_d = pend_h_q;
          res_data_d    = data_q;
        end else begin
          res_hvld_d    = 1'b0;
          res_handler_d = '0;
          res_data_d    = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fault_q    <= 1'b0;
      found_q    <= 1'b0;
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      fault_q    <= fault_d;
      found_q    <= found_d;
      pend_vld_q <= pend_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    ev_q          <= ev_d;
    prio_q        <= prio_d;
    hid_q         <= hid_d;
    data_q        <= data_d;
    n_q           <= n_d;
    pos_q         <= pos_d;
    pend_h_q      <= pend_h_d;
    res_status_q  <= res_status_d;
    res_hvld_q    <= res_hvld_d;
    res_handler_q <= res_handler_d;
    res_event_q   <= res_event_d;
    res_data_q    <= res_data_d;
    res_fault_q   <= res_fault_d;
    res_last_q    <= res_last_d;
  end

  assign strobe_o        = res_vld_q;
  assign status_o        = res_status_q;
  assign handler_valid_o = res_hvld_q;
  assign handler_out_o   = res_handler_q;
  assign event_out_o     = res_event_q;
  assign data_out_o      = res_data_q;
  assign fault_o         = res_fault_q;
  assign last_o          = res_last_q;

`ifndef SYNTHESIS
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ent_we && ent_re) |-> (ent_waddr != ent_raddr))
    else $error("entry read and write hit the same slot");

  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q |=> fault_q)
    else $error("overflow fault cleared without reset");

  a_handler_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && handler_valid_o) |-> (handler_out_o != '0))
    else $error("dispatch word names handler zero");

  a_mid_word_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_o) |-> busy)
    else $error("non-final word after the item finished");
`endif

endmodule
